// ----- design/sde_pkg.sv -----
// Shared types and constants for the sorted divisor enumerator.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package sde_pkg;

    // Default width of the number that is examined.
    localparam int NUM_WIDTH_DEF = 13;

    // Up to 13 bits no number has more than 32 divisors at or below its square root.
    localparam int STACK_DEPTH = 32;

    // Depth of the queue between the trial divider and the output sequencer.
    localparam int QUEUE_DEPTH = 4;

    // Kinds of word that travel through the queue.
    localparam logic EV_FOUND = 1'b0;
    localparam logic EV_END   = 1'b1;

    typedef struct packed {
        logic kind;
        logic square;
        logic last;
    } ev_ctl_t;

endpackage

`default_nettype wire

// ----- design/sorted_divisor_enumerator_unit.sv -----
// Lists every divisor of a number in ascending order, one per strobe, the final one
// (the number itself) flagged by last. A number is taken when start is high and busy is
// low; a zero number gives no words. Results cannot be held off: each divisor is on
// divisor/last for exactly one cycle while strobe is high. Each trial divisor up to the
// square root is tested in the restoring divider of the front part, and a number occupies
// the block until its divisors above the square root have been played out.
// Built from sde_pkg, sde_front, sde_queue and sde_back.
`default_nettype none

module sorted_divisor_enumerator_unit #(
    parameter int NUM_WIDTH = sde_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUM_WIDTH-1:0] number,
    output logic                      busy,
    output logic                      strobe,
    output logic [NUM_WIDTH-1:0]      divisor,
    output logic                      last
);

    localparam int CTLW = $bits(sde_pkg::ev_ctl_t);
    localparam int QW   = CTLW + 2 * NUM_WIDTH;

    logic                 accept;
    logic                 front_busy, back_busy;
    logic                 q_push, q_pop, q_empty, q_full;
    sde_pkg::ev_ctl_t     f_ctl, b_ctl;
    logic [NUM_WIDTH-1:0] f_small, f_partner, b_small, b_partner;
    logic [QW-1:0]        q_wdata, q_rdata;

    assign accept  = start && !busy;
    assign busy    = front_busy || !q_empty || back_busy;
    assign q_wdata = {f_ctl, f_small, f_partner};
    assign b_ctl     = q_rdata[QW-1 -: CTLW];
    assign b_small   = q_rdata[2*NUM_WIDTH-1 -: NUM_WIDTH];
    assign b_partner = q_rdata[NUM_WIDTH-1:0];

    sde_front #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .number     (number),
        .full       (q_full),
        .busy       (front_busy),
        .push       (q_push),
        .ev_ctl     (f_ctl),
        .ev_small   (f_small),
        .ev_partner (f_partner)
    );

    sde_queue #(
        .DATA_WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    sde_back #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (q_empty),
        .ev_ctl     (b_ctl),
        .ev_small   (b_small),
        .ev_partner (b_partner),
        .pop        (q_pop),
        .busy       (back_busy),
        .strobe     (strobe),
        .divisor    (divisor),
        .last       (last)
    );

    // An accepted number keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after accepting a number");

    // The final divisor of a number is never followed straight away by another word.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("word emitted right after the final divisor");

    // The front part never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

endmodule

`default_nettype wire

// ----- design/sde_front.sv -----
// Front part: takes a number and runs trial division up to its square root.
// Uses sde_pkg for the word type it hands to the queue.
`default_nettype none

module sde_front #(
    parameter int NUM_WIDTH = sde_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [NUM_WIDTH-1:0] number,
    input  wire logic                 full,
    output logic                      busy,
    output logic                      push,
    output sde_pkg::ev_ctl_t          ev_ctl,
    output logic [NUM_WIDTH-1:0]      ev_small,
    output logic [NUM_WIDTH-1:0]      ev_partner
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CHECK = 2'd1;
    localparam logic [1:0] F_DIV   = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] i_reg, i_next;
    logic [NUM_WIDTH:0]   sq_reg, sq_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [CW-1:0]        step_reg, step_next;

    logic [NUM_WIDTH:0]   shifted;
    logic [NUM_WIDTH+1:0] diff;
    logic                 in_range;

    assign shifted  = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign diff     = {1'b0, shifted} - {2'b00, i_reg};
    assign in_range = (sq_reg <= {1'b0, n_reg});

    assign busy       = (state_reg != F_IDLE);
    assign ev_small   = i_reg;
    assign ev_partner = quo_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        push       = 1'b0;
        ev_ctl.kind   = sde_pkg::EV_FOUND;
        ev_ctl.square = (quo_reg == i_reg);
        ev_ctl.last   = (i_reg == n_reg);

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    n_next     = number;
                    i_next     = NUM_WIDTH'(1);
                    sq_next    = (NUM_WIDTH + 1)'(1);
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                if (in_range)
                begin
                    rem_next   = '0;
                    quo_next   = n_reg;
                    step_next  = CW'(NUM_WIDTH);
                    state_next = F_DIV;
                end
                else
                begin
                    // Search is over: tell the back part to play out the partners.
                    ev_ctl.kind = sde_pkg::EV_END;
                    push        = !full;
                    if (!full)
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            F_DIV:
            begin
                // One restoring division step per cycle.
                if (diff[NUM_WIDTH+1])
                begin
                    rem_next = shifted[NUM_WIDTH-1:0];
                end
                else
                begin
                    rem_next = diff[NUM_WIDTH-1:0];
                end
                quo_next  = {quo_reg[NUM_WIDTH-2:0], !diff[NUM_WIDTH+1]};
                step_next = step_reg - CW'(1);
                if (step_reg == CW'(1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if ((rem_reg == '0) && full)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    push       = (rem_reg == '0);
                    i_next     = i_reg + NUM_WIDTH'(1);
                    sq_next    = sq_reg + {i_reg, 1'b1};
                    state_next = F_CHECK;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

endmodule

`default_nettype wire

// ----- design/sde_queue.sv -----
// Short first-in first-out queue that decouples the trial divider from the output side.
// Depth comes from sde_pkg; the word width is set by the instantiating module.
`default_nettype none

module sde_queue #(
    parameter int DATA_WIDTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic                  pop,
    output logic [DATA_WIDTH-1:0]      rdata,
    output logic                       empty,
    output logic                       full
);

    localparam int DEPTH = sde_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]       count_reg, count_next;
    logic                  do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNTW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- design/sde_back.sv -----
// Back part: emits small divisors as they arrive and stacks their partners,
// then plays the stack out in reverse. Uses sde_pkg for the word type and stack depth.
`default_nettype none

module sde_back #(
    parameter int NUM_WIDTH = sde_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 empty,
    input  wire sde_pkg::ev_ctl_t     ev_ctl,
    input  wire logic [NUM_WIDTH-1:0] ev_small,
    input  wire logic [NUM_WIDTH-1:0] ev_partner,
    output logic                      pop,
    output logic                      busy,
    output logic                      strobe,
    output logic [NUM_WIDTH-1:0]      divisor,
    output logic                      last
);

    localparam int SW = $clog2(sde_pkg::STACK_DEPTH);

    localparam logic B_EMIT  = 1'b0;
    localparam logic B_DRAIN = 1'b1;

    logic [NUM_WIDTH-1:0] stack_mem [sde_pkg::STACK_DEPTH];
    logic                 state_reg, state_next;
    logic [SW:0]          cnt_reg, cnt_next;
    logic                 strobe_reg, strobe_next;
    logic [NUM_WIDTH-1:0] divisor_reg;
    logic                 last_reg;
    logic                 take_found, stack_push, stack_pop;
    logic [SW:0]          top_idx;

    assign pop        = (state_reg == B_EMIT) && !empty;
    assign take_found = pop && (ev_ctl.kind == sde_pkg::EV_FOUND);
    assign stack_push = take_found && !ev_ctl.square;
    assign stack_pop  = (state_reg == B_DRAIN) && (cnt_reg != '0);
    assign top_idx    = cnt_reg - (SW + 1)'(1);

    assign busy    = (state_reg == B_DRAIN);
    assign strobe  = strobe_reg;
    assign divisor = divisor_reg;
    assign last    = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        strobe_next = take_found || stack_pop;
        unique case (state_reg)
            B_EMIT:
            begin
                if (stack_push)
                begin
                    cnt_next = cnt_reg + (SW + 1)'(1);
                end
                if (pop && (ev_ctl.kind == sde_pkg::EV_END) && (cnt_reg != '0))
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - (SW + 1)'(1);
                end
                if (cnt_reg <= (SW + 1)'(1))
                begin
                    state_next = B_EMIT;
                end
            end
            default:
            begin
                state_next = B_EMIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_EMIT;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    // The partner of 1 is the number itself and sits at the bottom of the stack.
    always_ff @(posedge clk)
    begin
        if (stack_push)
        begin
            stack_mem[cnt_reg[SW-1:0]] <= ev_partner;
        end
        if (stack_pop)
        begin
            divisor_reg <= stack_mem[top_idx[SW-1:0]];
            last_reg    <= (cnt_reg == (SW + 1)'(1));
        end
        else if (take_found)
        begin
            divisor_reg <= ev_small;
            last_reg    <= ev_ctl.last;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for sorted_divisor_enumerator_unit: a directed table of numbers, then
// random numbers; each word is checked against a given list or a trial-division predictor.
// Depends on sde_pkg and the design top level only.
`default_nettype none

module tb_top;

    localparam int NW             = sde_pkg::NUM_WIDTH_DEF;
    localparam int RANDOM_NUMBERS = 90;
    localparam int DRAIN_CYCLES   = 2000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DIRECTED_ROWS  = 21;

    typedef struct packed {
        logic [NW-1:0] divisor;
        logic          last;
    } div_word_t;

    // A row either carries its divisors written out, or leaves them to the predictor.
    typedef struct packed {
        logic [NW-1:0]        value;
        logic                 given;
        logic [2:0]           n_given;
        logic [0:3][NW-1:0]   divs;
    } stim_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic [NW-1:0] number = '0;
    logic          busy;
    logic          strobe;
    logic [NW-1:0] divisor;
    logic          last;

    div_word_t pending_divisors[$];
    int        mismatch_count = 0;

    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{13'd0,    1'b1, 3'd0, '{4{13'd0}}},
        '{13'd1,    1'b1, 3'd1, '{13'd1, 13'd0, 13'd0, 13'd0}},
        '{13'd2,    1'b1, 3'd2, '{13'd1, 13'd2, 13'd0, 13'd0}},
        '{13'd3,    1'b1, 3'd2, '{13'd1, 13'd3, 13'd0, 13'd0}},
        '{13'd4,    1'b1, 3'd3, '{13'd1, 13'd2, 13'd4, 13'd0}},
        '{13'd6,    1'b1, 3'd4, '{13'd1, 13'd2, 13'd3, 13'd6}},
        '{13'd9,    1'b1, 3'd3, '{13'd1, 13'd3, 13'd9, 13'd0}},
        '{13'd8191, 1'b1, 3'd2, '{13'd1, 13'd8191, 13'd0, 13'd0}},
        '{13'd8191, 1'b1, 3'd2, '{13'd1, 13'd8191, 13'd0, 13'd0}},
        '{13'd1,    1'b1, 3'd1, '{13'd1, 13'd0, 13'd0, 13'd0}},
        '{13'd7560, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd4096, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd8190, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd8100, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd7921, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd4095, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd5461, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd2730, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd0,    1'b1, 3'd0, '{4{13'd0}}},
        '{13'd4097, 1'b0, 3'd0, '{4{13'd0}}},
        '{13'd12,   1'b0, 3'd0, '{4{13'd0}}}
    };

    sorted_divisor_enumerator_unit #(
        .NUM_WIDTH(NW)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .number (number),
        .busy   (busy),
        .strobe (strobe),
        .divisor(divisor),
        .last   (last)
    );

    always #2 clk = ~clk;

    // Divisors up to the square root in rising order, then their partners with the
    // square root itself left out, so the whole list comes out ascending.
    function automatic void list_divisors(input logic [NW-1:0] value);
        int unsigned low_divs[$];
        int unsigned n;
        int unsigned k;
        int unsigned partner;
        int          j;
        n = value;
        if (n == 0)
            return;
        for (k = 1; k * k <= n; k++)
        begin
            if (n % k == 0)
                low_divs.push_back(k);
        end
        for (j = 0; j < low_divs.size(); j++)
            pending_divisors.push_back('{divisor: NW'(low_divs[j]),
                                         last: (low_divs[j] == n)});
        for (j = low_divs.size() - 1; j >= 0; j--)
        begin
            if (low_divs[j] * low_divs[j] == n)
                continue;
            partner = n / low_divs[j];
            pending_divisors.push_back('{divisor: NW'(partner), last: (partner == n)});
        end
    endfunction

    // Returns once the number has been taken; start stays high so that a following
    // number with no gap goes straight in.
    task automatic send_number(input logic [NW-1:0] value, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        number <= value;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_for_divisors();
        start <= 1'b0;
        while (pending_divisors.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_words
        div_word_t want;
        if (rst_n && strobe)
        begin
            if (pending_divisors.size() == 0)
            begin
                $display("%0t: expected no word, got divisor=%0d last=%0b",
                         $time, divisor, last);
                mismatch_count++;
            end
            else
            begin
                want = pending_divisors.pop_front();
                if (divisor !== want.divisor)
                begin
                    $display("%0t: divisor expected %0d, got %0d",
                             $time, want.divisor, divisor);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b, got %0b (divisor %0d)",
                             $time, want.last, last, want.divisor);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (strobe || (start && !busy))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : stimulus
        int            i;
        int            k;
        int            gap;
        int            root;
        logic [NW-1:0] value;
        stim_row_t     row;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            gap = (i % 4 == 0) ? 0 : $urandom_range(0, 5);
            send_number(row.value, gap);
            if (row.given)
            begin
                for (k = 0; k < row.n_given; k++)
                    pending_divisors.push_back('{divisor: row.divs[k],
                                                 last: (k == row.n_given - 1)});
            end
            else
                list_divisors(row.value);
        end

        // Let the block run dry before the random part starts.
        wait_for_divisors();

        for (i = 0; i < RANDOM_NUMBERS; i++)
        begin
            case ($urandom_range(0, 9))
                0:
                    value = '0;
                1, 2:
                begin
                    root  = $urandom_range(1, 90);
                    value = NW'(root * root);
                end
                3, 4, 5:
                    value = NW'($urandom_range(1, 255));
                default:
                    value = NW'($urandom_range(1, (1 << NW) - 1));
            endcase
            // Every third stretch of ten numbers goes in back to back.
            gap = ((i / 10) % 3 == 1) ? 0 : $urandom_range(0, 5);
            send_number(value, gap);
            list_divisors(value);
            if (i == RANDOM_NUMBERS / 2)
                wait_for_divisors();
        end

        wait_for_divisors();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_divisors.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
